FILE: rtl/rau_pkg.sv
`default_nettype none

package rau_pkg;

    // operation codes
    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_CMP = 3'd4;

    // product slots, one multiplication each
    localparam logic [1:0] PROD_LN_RD = 2'd0;
    localparam logic [1:0] PROD_RN_LD = 2'd1;
    localparam logic [1:0] PROD_LN_RN = 2'd2;
    localparam logic [1:0] PROD_DEN   = 2'd3;

    localparam int unsigned DIV_STEPS = 64;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       form;
        logic       norm;
        logic       gcd_step;
        logic       shl;
        logic       div_start_num;
        logic       div_start_den;
        logic       div_step;
        logic       save_qd;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic arith;
        logic den_zero;
        logic gcd_done;
        logic k_zero;
        logic div_done;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/rau_if.sv
`default_nettype none

interface rau_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  kind;
    logic signed [31:0] left_num;
    logic        [30:0] left_den;
    logic signed [31:0] right_num;
    logic        [30:0] right_den;

    modport source (output valid, kind, left_num, left_den, right_num, right_den,
                    input ready);
    modport sink   (input valid, kind, left_num, left_den, right_num, right_den,
                    output ready);
endinterface

interface rau_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_num;
    logic        [30:0] res_den;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               overflow;

    modport source (output valid, res_num, res_den, is_less, is_equal, is_greater,
                    overflow, input ready);
    modport sink   (input valid, res_num, res_den, is_less, is_equal, is_greater,
                    overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/rau_dp.sv
`default_nettype none

module rau_dp #(
    parameter int WORD_BITS = 32
) (
    input  wire                 i_clk,
    input  wire rau_pkg::t_cmd  i_cmd,
    input  wire         [2:0]   i_kind,
    input  wire signed  [31:0]  i_left_num,
    input  wire         [30:0]  i_left_den,
    input  wire signed  [31:0]  i_right_num,
    input  wire         [30:0]  i_right_den,
    output rau_pkg::t_stat      o_stat,
    output logic signed [31:0]  o_res_num,
    output logic        [30:0]  o_res_den,
    output logic                o_is_less,
    output logic                o_is_equal,
    output logic                o_is_greater,
    output logic                o_overflow
);

    localparam logic [63:0] LIMIT = (64'd1 << (WORD_BITS - 1)) - 64'd1;

    logic        [2:0]  r_kind;
    logic signed [32:0] r_ln, r_ld, r_rn, r_rd;
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [63:0] r_num, r_den;
    logic        [63:0] r_mn, r_md, r_a, r_b, r_qn, r_qd;
    logic        [63:0] r_dvd, r_rem;
    logic        [6:0]  r_k, r_cnt;
    logic               r_neg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [63:0] nrm_num;
    logic        [63:0] nrm_den, nrm_mag, zero_mag;
    logic        [64:0] rem_sh;
    logic               rem_ge;
    logic               out_ovf;

    // pick the operand pair for this multiply cycle
    always_comb begin
        case (i_cmd.mul_sel)
            rau_pkg::PROD_LN_RD: begin mul_a = r_ln; mul_b = r_rd; end
            rau_pkg::PROD_RN_LD: begin mul_a = r_rn; mul_b = r_ld; end
            rau_pkg::PROD_LN_RN: begin mul_a = r_ln; mul_b = r_rn; end
            default: begin
                mul_a = r_ld;
                mul_b = (r_kind == rau_pkg::KIND_DIV) ? r_rn : r_rd;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // move sign onto the numerator
    always_comb begin
        nrm_num  = r_den[63] ? -r_num : r_num;
        nrm_den  = r_den[63] ? 64'(-r_den) : 64'(r_den);
        nrm_mag  = nrm_num[63] ? 64'(-nrm_num) : 64'(nrm_num);
        zero_mag = r_num[63] ? 64'(-r_num) : 64'(r_num);
        rem_sh   = {r_rem, r_dvd[63]};
        rem_ge   = rem_sh >= {1'b0, r_b};
        out_ovf  = (r_qn > LIMIT) || (r_qd > LIMIT);
    end

    always_ff @(posedge i_clk) begin
        // capture the operands
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_ln   <= 33'(i_left_num);
            r_rn   <= 33'(i_right_num);
            r_ld   <= {2'b00, i_left_den};
            r_rd   <= {2'b00, i_right_den};
        end
        // hold one product per cycle
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                rau_pkg::PROD_LN_RD: r_p0 <= mul_p[63:0];
                rau_pkg::PROD_RN_LD: r_p1 <= mul_p[63:0];
                rau_pkg::PROD_LN_RN: r_p2 <= mul_p[63:0];
                default:             r_p3 <= mul_p[63:0];
            endcase
        end
        // combine products into numerator and denominator
        if (i_cmd.form) begin
            case (r_kind)
                rau_pkg::KIND_ADD: r_num <= r_p0 + r_p1;
                rau_pkg::KIND_SUB: r_num <= r_p0 - r_p1;
                rau_pkg::KIND_MUL: r_num <= r_p2;
                default:           r_num <= r_p0;
            endcase
            r_den <= r_p3;
        end
        // normalize sign and seed the gcd, or load the result directly for a zero denominator
        if (i_cmd.norm) begin
            if (r_den == 64'sd0) begin
                r_qn  <= zero_mag;
                r_qd  <= 64'd1;
                r_neg <= r_num[63];
            end else begin
                r_mn  <= nrm_mag;
                r_md  <= nrm_den;
                r_a   <= nrm_mag;
                r_b   <= nrm_den;
                r_k   <= 7'd0;
                r_neg <= nrm_num[63];
            end
        end
        // binary gcd, one step a cycle
        if (i_cmd.gcd_step) begin
            if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 7'd1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end
        // restore common factors of two
        if (i_cmd.shl) begin
            r_b <= r_b << 1;
            r_k <= r_k - 7'd1;
        end
        // restoring division by the gcd
        if (i_cmd.div_start_num || i_cmd.div_start_den) begin
            r_dvd <= i_cmd.div_start_num ? r_mn : r_md;
            r_rem <= 64'd0;
            r_cnt <= 7'(rau_pkg::DIV_STEPS);
        end
        if (i_cmd.div_start_den) begin
            r_qn <= r_dvd;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? 64'(rem_sh - {1'b0, r_b}) : rem_sh[63:0];
            r_dvd <= {r_dvd[62:0], rem_ge};
            r_cnt <= r_cnt - 7'd1;
        end
        if (i_cmd.save_qd) begin
            r_qd <= r_dvd;
        end
        // register the result
        if (i_cmd.out_load) begin
            o_is_less    <= (r_kind == rau_pkg::KIND_CMP) && (r_p0 < r_p1);
            o_is_equal   <= (r_kind == rau_pkg::KIND_CMP) && (r_p0 == r_p1);
            o_is_greater <= (r_kind == rau_pkg::KIND_CMP) && (r_p0 > r_p1);
            o_overflow   <= (r_kind < rau_pkg::KIND_CMP) && out_ovf;
            if ((r_kind < rau_pkg::KIND_CMP) && !out_ovf) begin
                o_res_num <= r_neg ? -r_qn[31:0] : r_qn[31:0];
                o_res_den <= r_qd[30:0];
            end else begin
                o_res_num <= '0;
                o_res_den <= '0;
            end
        end
    end

    assign o_stat.arith    = r_kind < rau_pkg::KIND_CMP;
    assign o_stat.den_zero = r_den == 64'sd0;
    assign o_stat.gcd_done = r_a == 64'd0;
    assign o_stat.k_zero   = r_k == 7'd0;
    assign o_stat.div_done = r_cnt == 7'd0;

endmodule

`default_nettype wire

FILE: rtl/rau_ctrl.sv
`default_nettype none

module rau_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    input  wire                  i_res_ready,
    input  wire rau_pkg::t_stat  i_stat,
    output logic                 o_req_ready,
    output logic                 o_res_valid,
    output rau_pkg::t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_FORM, S_NORM, S_GCD, S_SHL, S_DIVN, S_DIVD, S_FIN
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_mcnt, n_mcnt;
    logic       r_out_valid, n_out_valid;

    // sequence the datapath
    always_comb begin
        n_state     = r_state;
        n_mcnt      = r_mcnt;
        n_out_valid = r_out_valid && !i_res_ready;
        o_cmd       = '0;
        o_cmd.mul_sel = r_mcnt;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_mcnt     = 2'd0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_mcnt       = r_mcnt + 2'd1;
                if (r_mcnt == rau_pkg::PROD_DEN) begin
                    n_state = i_stat.arith ? S_FORM : S_FIN;
                end
            end
            S_FORM: begin
                o_cmd.form = 1'b1;
                n_state    = S_NORM;
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                n_state    = i_stat.den_zero ? S_FIN : S_GCD;
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    n_state = S_SHL;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_SHL: begin
                if (i_stat.k_zero) begin
                    o_cmd.div_start_num = 1'b1;
                    n_state             = S_DIVN;
                end else begin
                    o_cmd.shl = 1'b1;
                end
            end
            S_DIVN: begin
                if (i_stat.div_done) begin
                    o_cmd.div_start_den = 1'b1;
                    n_state             = S_DIVD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DIVD: begin
                if (i_stat.div_done) begin
                    o_cmd.save_qd = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_res_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mcnt      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mcnt      <= n_mcnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = r_state == S_IDLE;
    assign o_res_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/rational_arith_unit.sv
`default_nettype none

// Channel   Dir  Modport  Fields
// i_req     in   sink     kind, left_num, left_den, right_num, right_den
// o_res     out  source   res_num, res_den, is_less, is_equal, is_greater, overflow
//
// One request at a time. Compare and unused kinds register a result once the products
// are done (four products on one shared 33x33 multiplier); a zero result denominator
// adds the forming and sign normalization. Other arithmetic adds a binary gcd at
// one step a cycle, the shift-back of the common power of two and two 64-step
// restoring divisions. Reset is synchronous, active low, and clears only the
// controller. A request is taken while the previous result still waits in the output.

module rational_arith_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    rau_req_if.sink   i_req,
    rau_res_if.source o_res
);

    rau_pkg::t_cmd  cmd;
    rau_pkg::t_stat stat;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_res_ready (o_res.ready),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_res_valid (o_res.valid),
        .o_cmd       (cmd)
    );

    rau_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_kind       (i_req.kind),
        .i_left_num   (i_req.left_num),
        .i_left_den   (i_req.left_den),
        .i_right_num  (i_req.right_num),
        .i_right_den  (i_req.right_den),
        .o_stat       (stat),
        .o_res_num    (o_res.res_num),
        .o_res_den    (o_res.res_den),
        .o_is_less    (o_res.is_less),
        .o_is_equal   (o_res.is_equal),
        .o_is_greater (o_res.is_greater),
        .o_overflow   (o_res.overflow)
    );

endmodule

`default_nettype wire
